FILE: design/hrt_pkg.sv
// Shared types, byte codes and tag codes for the HTTP request head tokenizer.
package hrt_pkg;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_COLON = 8'h3A;

	typedef enum logic [2:0] {
		PH_METHOD  = 3'd0,
		PH_TARGET  = 3'd1,
		PH_VERSION = 3'd2,
		PH_NAME    = 3'd3,
		PH_BLANKS  = 3'd4,
		PH_VALUE   = 3'd5,
		PH_BODY    = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		TAG_METHOD  = 3'd0,
		TAG_TARGET  = 3'd1,
		TAG_VERSION = 3'd2,
		TAG_NAME    = 3'd3,
		TAG_VALUE   = 3'd4,
		TAG_DELIM   = 3'd5,
		TAG_BODY    = 3'd6
	} tag_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_LINE = 2'd1,
		ST_NO_END   = 2'd2
	} status_t;

	// Progress through the CRLFCRLF terminator.
	typedef enum logic [1:0] {
		TP_NONE    = 2'd0,
		TP_CR      = 2'd1,
		TP_CRLF    = 2'd2,
		TP_CRLFCR  = 2'd3
	} term_t;

	typedef struct packed {
		logic [7:0] data_in;
		logic       buffer_end;
	} byte_item_t;

	typedef struct packed {
		logic [7:0] data_out;
		tag_t       byte_tag;
		logic       line_end;
		logic       header_kept;
		logic       head_done;
		status_t    status;
		logic       last_result;
	} tag_item_t;

	typedef struct packed {
		phase_t     phase;
		logic [1:0] spaces_seen;
		logic       colon_seen;
		term_t      term_prog;
		logic       request_bad;
	} tok_state_t;

	// One classification request: the byte, its lookahead and the end mark.
	typedef struct packed {
		logic [7:0] cur_byte;
		logic       has_next;
		logic [7:0] next_byte;
		logic       last;
	} cls_req_t;

	localparam tok_state_t TOK_STATE_RESET = '{
		phase:       PH_METHOD,
		spaces_seen: 2'd0,
		colon_seen:  1'b0,
		term_prog:   TP_NONE,
		request_bad: 1'b0
	};

endpackage

FILE: design/http_request_head_tokenizer_core.sv
// Top level of the HTTP request head tokenizer: input register, byte hold and tagging.
//
//   channel   | direction | handshake              | payload
//   ----------+-----------+------------------------+--------------------------------
//   byte_*    | in        | byte_valid/byte_stall  | byte_item (data_in, buffer_end)
//   tag_*     | out       | tag_valid/tag_stall    | tag_item (byte, tag, flags)
//
// One byte is taken per cycle unless byte_stall holds it off. Results lag by one
// byte: a byte is tagged when its successor arrives, since a CR is only a delimiter
// when an LF follows. A byte marked buffer_end with a byte held yields two results
// (held byte, then itself), so that transfer stays in the tagging stage for both.
// With no output stall a result passes the input register, then the output register.
// Reset (arst_n low) clears the tokenizer state, the hold and both stages.
// An output stall fills the skid entry first; the input stalls only once the
// input register holds a byte that cannot move on.
module http_request_head_tokenizer_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  hrt_pkg::byte_item_t byte_item,
	output logic                tag_valid,
	input  logic                tag_stall,
	output hrt_pkg::tag_item_t  tag_item
);

	// Input register
	logic                valid_s1;
	hrt_pkg::byte_item_t item_s1;

	// Tokenizer state and the byte held back for lookahead
	hrt_pkg::tok_state_t state_q;
	logic [7:0]          held_q;
	logic                held_valid_q;
	// Set once the held byte of a final input has been tagged
	logic                held_done_q;

	logic                byte_accept;
	logic                need_held;
	logic                emit;
	logic                can_push;
	logic                advance;
	hrt_pkg::cls_req_t   cls_req;
	hrt_pkg::tok_state_t cls_nxt;
	hrt_pkg::tag_item_t  cls_res;

	// The held byte goes first; the input byte is tagged now only when it ends the buffer.
	assign need_held = held_valid_q && !held_done_q;
	assign emit      = valid_s1 && (need_held || item_s1.buffer_end);
	// Advance the stage when nothing is emitted or the result has room.
	assign advance   = valid_s1 && (!emit || can_push);

	assign cls_req.cur_byte  = need_held ? held_q : item_s1.data_in;
	assign cls_req.has_next  = need_held;
	assign cls_req.next_byte = item_s1.data_in;
	assign cls_req.last      = !need_held;

	// Stall the input while the registered byte stays (held part of a final byte
	// done, or no room for its result).
	assign byte_stall  = valid_s1 && !(advance && !(need_held && item_s1.buffer_end));
	assign byte_accept = byte_valid && !byte_stall;

	hrt_classify u_classify (
		.cur (state_q),
		.req (cls_req),
		.nxt (cls_nxt),
		.res (cls_res)
	);

	hrt_out_skid u_out_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit && can_push),
		.push_item (cls_res),
		.can_push  (can_push),
		.out_valid (tag_valid),
		.out_stall (tag_stall),
		.out_item  (tag_item)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_accept) begin
			valid_s1 <= 1'b1;
		end else if (!byte_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_accept) begin
			item_s1 <= byte_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= hrt_pkg::TOK_STATE_RESET;
			held_q       <= 8'd0;
			held_valid_q <= 1'b0;
			held_done_q  <= 1'b0;
		end else if (advance) begin
			if (need_held) begin
				state_q <= cls_nxt;
				if (item_s1.buffer_end) begin
					// Keep the final byte in the input register so it is tagged itself.
					held_done_q <= 1'b1;
				end else begin
					held_q <= item_s1.data_in;
				end
			end else if (item_s1.buffer_end) begin
				// Final result is out: drop everything back to reset.
				state_q      <= hrt_pkg::TOK_STATE_RESET;
				held_q       <= 8'd0;
				held_valid_q <= 1'b0;
				held_done_q  <= 1'b0;
			end else begin
				held_q       <= item_s1.data_in;
				held_valid_q <= 1'b1;
			end
		end
	end

	// The held part of a final byte is done only while that byte waits in the stage.
	a_held_done_final: assert property (@(posedge clk) disable iff (!arst_n)
		held_done_q |-> (valid_s1 && item_s1.buffer_end && held_valid_q))
		else $error("held_done set without a final byte waiting");

	// A pending skid entry always sits behind a valid output register.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		!can_push |-> tag_valid)
		else $error("skid entry valid while output register is empty");

	// The head terminator is always an LF delimiter that ends a line.
	a_done_is_lf: assert property (@(posedge clk) disable iff (!arst_n)
		(tag_valid && tag_item.head_done) |->
			(tag_item.line_end && tag_item.byte_tag == hrt_pkg::TAG_DELIM &&
			 tag_item.data_out == hrt_pkg::CH_LF))
		else $error("head_done on a result that is not a line-ending LF");

	// After a final result is sent, the hold is empty, so the next buffer starts fresh.
	a_last_clears_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !need_held && item_s1.buffer_end) |=> !held_valid_q)
		else $error("hold not cleared after the final byte");

endmodule

FILE: design/hrt_classify.sv
// Combinational tagging of one byte and the tokenizer state update it causes.
module hrt_classify (
	input  hrt_pkg::tok_state_t cur,
	input  hrt_pkg::cls_req_t   req,
	output hrt_pkg::tok_state_t nxt,
	output hrt_pkg::tag_item_t  res
);

	logic crlf_cr;
	logic term_lf;

	assign crlf_cr = (req.cur_byte == hrt_pkg::CH_CR) && req.has_next &&
		(req.next_byte == hrt_pkg::CH_LF);
	assign term_lf = (req.cur_byte == hrt_pkg::CH_LF) &&
		((cur.term_prog == hrt_pkg::TP_CR) || (cur.term_prog == hrt_pkg::TP_CRLFCR));

	always_comb begin
		nxt             = cur;
		res.data_out    = req.cur_byte;
		res.byte_tag    = hrt_pkg::TAG_METHOD;
		res.line_end    = 1'b0;
		res.header_kept = 1'b0;
		res.head_done   = 1'b0;
		res.status      = hrt_pkg::ST_OK;
		res.last_result = req.last;

		if (cur.phase >= hrt_pkg::PH_BODY) begin
			res.byte_tag = hrt_pkg::TAG_BODY;
		end else if (crlf_cr) begin
			res.byte_tag  = hrt_pkg::TAG_DELIM;
			nxt.term_prog = (cur.term_prog == hrt_pkg::TP_CRLF) ?
				hrt_pkg::TP_CRLFCR : hrt_pkg::TP_CR;
		end else if (term_lf) begin
			res.byte_tag = hrt_pkg::TAG_DELIM;
			res.line_end = 1'b1;
			if (cur.term_prog == hrt_pkg::TP_CRLFCR) begin
				res.head_done = 1'b1;
				nxt.phase     = hrt_pkg::PH_BODY;
				nxt.term_prog = hrt_pkg::TP_NONE;
				res.status    = cur.request_bad ? hrt_pkg::ST_BAD_LINE : hrt_pkg::ST_OK;
			end else begin
				// End of the request line or of a header line.
				if (cur.phase <= hrt_pkg::PH_VERSION) begin
					if (cur.spaces_seen < 2'd2) begin
						nxt.request_bad = 1'b1;
					end
				end else begin
					res.header_kept = cur.colon_seen;
				end
				nxt.colon_seen = 1'b0;
				nxt.phase      = hrt_pkg::PH_NAME;
				nxt.term_prog  = hrt_pkg::TP_CRLF;
			end
		end else begin
			nxt.term_prog = hrt_pkg::TP_NONE;
			unique case (cur.phase)
				hrt_pkg::PH_METHOD: begin
					if (req.cur_byte == hrt_pkg::CH_SP) begin
						res.byte_tag    = hrt_pkg::TAG_DELIM;
						nxt.spaces_seen = 2'd1;
						nxt.phase       = hrt_pkg::PH_TARGET;
					end else begin
						res.byte_tag = hrt_pkg::TAG_METHOD;
					end
				end
				hrt_pkg::PH_TARGET: begin
					if (req.cur_byte == hrt_pkg::CH_SP) begin
						res.byte_tag    = hrt_pkg::TAG_DELIM;
						nxt.spaces_seen = 2'd2;
						nxt.phase       = hrt_pkg::PH_VERSION;
					end else begin
						res.byte_tag = hrt_pkg::TAG_TARGET;
					end
				end
				hrt_pkg::PH_VERSION: begin
					res.byte_tag = hrt_pkg::TAG_VERSION;
				end
				hrt_pkg::PH_NAME: begin
					if (req.cur_byte == hrt_pkg::CH_COLON) begin
						res.byte_tag   = hrt_pkg::TAG_DELIM;
						nxt.colon_seen = 1'b1;
						nxt.phase      = hrt_pkg::PH_BLANKS;
					end else begin
						res.byte_tag = hrt_pkg::TAG_NAME;
					end
				end
				hrt_pkg::PH_BLANKS: begin
					if ((req.cur_byte == hrt_pkg::CH_SP) ||
						(req.cur_byte == hrt_pkg::CH_TAB)) begin
						res.byte_tag = hrt_pkg::TAG_DELIM;
					end else begin
						res.byte_tag = hrt_pkg::TAG_VALUE;
						nxt.phase    = hrt_pkg::PH_VALUE;
					end
				end
				default: begin
					res.byte_tag = hrt_pkg::TAG_VALUE;
				end
			endcase
		end

		if (req.last) begin
			if (nxt.phase < hrt_pkg::PH_BODY) begin
				res.status = hrt_pkg::ST_NO_END;
			end else begin
				res.status = nxt.request_bad ? hrt_pkg::ST_BAD_LINE : hrt_pkg::ST_OK;
			end
		end
	end

endmodule

FILE: design/hrt_out_skid.sv
// Output register with a one-entry skid stage for tagged results.
module hrt_out_skid (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  hrt_pkg::tag_item_t push_item,
	output logic               can_push,
	output logic               out_valid,
	input  logic               out_stall,
	output hrt_pkg::tag_item_t out_item
);

	logic               out_valid_q;
	hrt_pkg::tag_item_t out_q;
	logic               skid_valid_q;
	hrt_pkg::tag_item_t skid_q;
	logic               pop;

	assign pop       = out_valid_q && !out_stall;
	assign can_push  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_q <= push_item;
			end else begin
				out_q <= push_item;
			end
		end
	end

endmodule
